### hw/rtl/lse_pkg.sv
// Package for the LIFO stack engine: stack depth, derived widths,
// operation and status codes. No dependencies.
package lse_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int DATA_W = 32;
  localparam int PTR_W = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  typedef logic [1:0] op_t;
  typedef logic [1:0] status_t;
  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam op_t OP_PUSH = 2'd0;
  localparam op_t OP_POP = 2'd1;
  localparam op_t OP_PEEK = 2'd2;
  localparam op_t OP_CLEAR = 2'd3;

  localparam status_t ST_OK = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL = 2'd2;

endpackage

### hw/rtl/lse_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// Self-contained; no package dependencies.
module lse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### hw/rtl/lifo_stack_engine.sv
// Top level of the LIFO stack engine: request decode, top pointer and
// result register around one stack RAM. Depends on lse_pkg and lse_ram.
//
// A request (operation, push_value) is transferred when in_valid is high and
// in_stall is low. Each request gives exactly one result (read_value, status,
// entry_count, is_empty), transferred when out_valid is high and out_stall is
// low. The result is held in an output register.
// Push, clear, and a pop or peek on an empty stack need no RAM read: the
// result is valid in the cycle after the request transfer, and a new request
// can be taken every cycle while out_stall does not hold a waiting result. A
// pop or peek on a non-empty stack reads the stack RAM, whose read port is
// registered, so the result passes the RAM read register and then the output
// register; in_stall holds off the next request while the read is pending.
// A push onto a full stack is dropped with status full; a pop or peek on an
// empty stack returns zero with status empty.
// Reset empties the stack and drops any pending result; the RAM contents are
// not cleared. While the receiver stalls a waiting result, in_stall is high
// and the result holds.
module lifo_stack_engine (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lse_pkg::op_t          operation,
  input  logic signed [31:0]    push_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [31:0]    read_value,
  output lse_pkg::status_t      status,
  output logic [7:0]            entry_count,
  output logic                  is_empty
);
  import lse_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic    state;
  ptr_t    top_pointer;
  ptr_t    top_pointer_next;
  ptr_t    ptr_dec;
  logic    accept;
  logic    ram_we;
  logic    need_read;
  addr_t   ram_addr;
  status_t status_next;
  logic [DATA_W-1:0] ram_rdata;

  assign in_stall = (state == S_READ) || (out_valid && out_stall);
  assign accept = in_valid && !in_stall;
  assign ptr_dec = top_pointer - ptr_t'(1);

  always_comb begin
    top_pointer_next = top_pointer;
    status_next = ST_OK;
    ram_we = 1'b0;
    need_read = 1'b0;
    ram_addr = ptr_dec[ADDR_W-1:0];
    unique case (operation)
      OP_PUSH: begin
        ram_addr = top_pointer[ADDR_W-1:0];
        if (top_pointer == ptr_t'(STACK_DEPTH)) begin
          status_next = ST_FULL;
        end else begin
          ram_we = accept;
          top_pointer_next = top_pointer + ptr_t'(1);
        end
      end
      OP_POP: begin
        if (top_pointer == '0) begin
          status_next = ST_EMPTY;
        end else begin
          need_read = 1'b1;
          top_pointer_next = ptr_dec;
        end
      end
      OP_PEEK: begin
        if (top_pointer == '0) begin
          status_next = ST_EMPTY;
        end else begin
          need_read = 1'b1;
        end
      end
      OP_CLEAR: begin
        top_pointer_next = '0;
      end
      default: begin
        top_pointer_next = top_pointer;
      end
    endcase
  end

  lse_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (push_value),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      top_pointer <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (state == S_READ) begin
        state <= S_IDLE;
        out_valid <= 1'b1;
      end
      if (accept) begin
        top_pointer <= top_pointer_next;
        if (need_read) begin
          state <= S_READ;
        end else begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      read_value <= ram_rdata;
    end
    if (accept) begin
      read_value <= '0;
      status <= status_next;
      entry_count <= 8'(top_pointer_next);
      is_empty <= (top_pointer_next == '0);
    end
  end

  a_read_no_output: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> !out_valid)
    else $error("result shown while a stack read is pending");

  a_read_stalls_input: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> in_stall)
    else $error("request taken while a stack read is pending");

  a_pointer_range: assert property (@(posedge clk) disable iff (rst)
    top_pointer <= ptr_t'(STACK_DEPTH))
    else $error("top pointer beyond stack depth");

  a_push_advances: assert property (@(posedge clk) disable iff (rst)
    (accept && operation == OP_PUSH && top_pointer != ptr_t'(STACK_DEPTH))
    |=> (top_pointer == $past(top_pointer) + ptr_t'(1)))
    else $error("push did not advance the top pointer");

  a_read_gives_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> out_valid)
    else $error("stack read did not produce a result");

endmodule

### test/tb_lifo_stack_engine.sv
// Self-checking testbench for lifo_stack_engine: random and directed push, pop, peek and clear
// requests, each result checked against a behavioral stack mirror held in a small class.
// Depends on lse_pkg and the lifo_stack_engine RTL.
module tb_lifo_stack_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import lse_pkg::*;

  localparam int TOTAL_ITEMS = 1600;
  localparam int CALM_AFTER = 1450;

  typedef struct {
    logic signed [31:0] value;
    status_t            st;
    logic [7:0]         count;
    logic               empty;
  } answer_t;

  class stack_mirror;
    logic signed [31:0] words [STACK_DEPTH];
    ptr_t               held;
    answer_t            answers_due[$];
    int                 mismatches;

    function new();
      held = '0;
      mismatches = 0;
    endfunction

    function void apply_request(op_t op, logic signed [31:0] word);
      answer_t a;
      a.value = '0;
      a.st = ST_OK;
      case (op)
        OP_PUSH: begin
          if (held == STACK_DEPTH) begin
            a.st = ST_FULL;
          end else begin
            words[held[ADDR_W-1:0]] = word;
            held++;
          end
        end
        OP_POP: begin
          if (held == 0) begin
            a.st = ST_EMPTY;
          end else begin
            held--;
            a.value = words[held[ADDR_W-1:0]];
          end
        end
        OP_PEEK: begin
          if (held == 0) begin
            a.st = ST_EMPTY;
          end else begin
            a.value = words[addr_t'(held - ptr_t'(1))];
          end
        end
        default: begin
          held = '0;
        end
      endcase
      a.count = 8'(held);
      a.empty = (held == 0);
      answers_due.push_back(a);
    endfunction

    function void flag(string field, logic [31:0] want, logic [31:0] got);
      if (mismatches < 20) begin
        $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
      end
      mismatches++;
    endfunction

    function void compare_answer(logic signed [31:0] value, status_t st, logic [7:0] count,
                                 logic empty);
      answer_t a;
      if (answers_due.size() == 0) begin
        flag("unrequested result, read_value", '0, value);
        return;
      end
      a = answers_due.pop_front();
      if (value !== a.value) begin
        flag("read_value", a.value, value);
      end
      if (st !== a.st) begin
        flag("status", a.st, st);
      end
      if (count !== a.count) begin
        flag("entry_count", a.count, count);
      end
      if (empty !== a.empty) begin
        flag("is_empty", a.empty, empty);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  op_t                operation = OP_PUSH;
  logic signed [31:0] push_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] read_value;
  status_t            status;
  logic [7:0]         entry_count;
  logic               is_empty;

  stack_mirror lifo;
  int          sent = 0;
  bit          gaps_on = 1'b1;
  bit          calm = 1'b0;

  lifo_stack_engine DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .operation(operation),
    .push_value(push_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .read_value(read_value),
    .status(status),
    .entry_count(entry_count),
    .is_empty(is_empty)
  );

  always #2 clk = ~clk;

  task automatic send_request(op_t op, logic signed [31:0] word);
    int gap;
    if (gaps_on && !calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    push_value <= word;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lifo.apply_request(op, word);
    sent++;
    if (sent >= CALM_AFTER) begin
      calm = 1'b1;
    end
  endtask

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 11))
      0: pick_word = 32'sh8000_0000;
      1: pick_word = 32'sh7fff_ffff;
      2: pick_word = '0;
      3: pick_word = -32'sd1;
      default: pick_word = $urandom;
    endcase
  endfunction

  function automatic op_t pick_op(int push_pct, int pop_pct, int peek_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < push_pct) begin
      pick_op = OP_PUSH;
    end else if (r < push_pct + pop_pct) begin
      pick_op = OP_POP;
    end else if (r < push_pct + pop_pct + peek_pct) begin
      pick_op = OP_PEEK;
    end else begin
      pick_op = OP_CLEAR;
    end
  endfunction

  task automatic run_mix(int n, int push_pct, int pop_pct, int peek_pct);
    repeat (n) send_request(pick_op(push_pct, pop_pct, peek_pct), pick_word());
  endtask

  initial begin : request_side
    int waited;
    lifo = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_request(OP_POP, 32'sh1234_5678);
    send_request(OP_PEEK, '0);
    send_request(OP_CLEAR, '0);
    send_request(OP_PUSH, 32'sh8000_0000);
    send_request(OP_PEEK, '0);
    send_request(OP_PUSH, 32'sh7fff_ffff);
    send_request(OP_PUSH, '0);
    send_request(OP_PUSH, -32'sd1);
    send_request(OP_PUSH, 32'sd1);
    send_request(OP_PEEK, '0);
    repeat (5) send_request(OP_POP, '0);
    send_request(OP_POP, '0);
    send_request(OP_PEEK, '0);
    send_request(OP_PUSH, 32'sha5a5_a5a5);
    send_request(OP_PUSH, 32'sh5a5a_5a5a);
    send_request(OP_CLEAR, -32'sd1);
    send_request(OP_PEEK, '0);
    send_request(OP_POP, '0);
    send_request(OP_PUSH, 32'sd123);
    send_request(OP_POP, '0);

    while (sent < TOTAL_ITEMS) begin
      gaps_on = ($urandom_range(0, 2) != 0);
      case ($urandom_range(0, 3))
        0: begin
          repeat (STACK_DEPTH + $urandom_range(1, 4)) send_request(OP_PUSH, pick_word());
          run_mix(8, 40, 0, 50);
        end
        1: run_mix(150, 10, 75, 13);
        2: run_mix(100, 45, 35, 17);
        default: run_mix(120, 80, 12, 8);
      endcase
    end
    in_valid <= 1'b0;

    waited = 0;
    while (lifo.answers_due.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (lifo.answers_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, lifo.answers_due.size());
      lifo.mismatches++;
    end
    if (lifo.mismatches == 0) begin
      $display("tb_lifo_stack_engine passed");
    end else begin
      $display("tb_lifo_stack_engine failed");
    end
    $finish;
  end

  initial begin : result_side
    int  stall_left;
    int  cycle;
    int  checked;
    bit  long_done;
    bit  bursty;
    stall_left = 0;
    cycle = 0;
    checked = 0;
    long_done = 1'b0;
    bursty = 1'b1;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (out_valid && !out_stall) begin
          lifo.compare_answer(read_value, status, entry_count, is_empty);
          checked++;
        end
        cycle++;
        if (cycle % 96 == 0) begin
          bursty = ($urandom_range(0, 2) != 0);
        end
        if (!long_done && checked >= 300) begin
          long_done = 1'b1;
          stall_left = 200;
        end
        if (stall_left > 0) begin
          out_stall <= 1'b1;
          stall_left--;
        end else if (bursty && !calm && $urandom_range(0, 4) == 0) begin
          out_stall <= 1'b1;
          stall_left = $urandom_range(0, 6);
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb_lifo_stack_engine failed");
    $finish;
  end

endmodule

### lifo_stack_engine.f
hw/rtl/lse_pkg.sv
hw/rtl/lse_ram.sv
hw/rtl/lifo_stack_engine.sv
test/tb_lifo_stack_engine.sv
